// ===== rtl/ekrs_pkg.sv =====
// shared types and constants for the earliest-k resource selector
package ekrs_pkg;

    localparam int IDX_W  = 4;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 5;
    localparam int RES_CAP = 16;

    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_SELECT   = 2'd1;
    localparam logic [1:0] REQ_CHECK    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  worker_id;
        logic [TIME_W-1:0] time_value;
        logic [CNT_W-1:0]  worker_count;
        logic [TIME_W-1:0] begin_time;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]  worker_index;
        logic [TIME_W-1:0] start_time;
        logic              ok;
        logic              error;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0] avail;
        logic [IDX_W-1:0]  id;
    } t_cell;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANK,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/ekrs_cell.sv =====
// one ring cell: holds a resource availability and its index, compares against a broadcast time if its index is active
module ekrs_cell import ekrs_pkg::*; #(
    parameter logic [IDX_W-1:0] POS = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  t_cell             i_next,
    input  logic              i_wr,
    input  logic [TIME_W-1:0] i_wr_time,
    input  logic [TIME_W-1:0] i_cmp_time,
    input  logic [CNT_W-1:0]  i_active,
    output t_cell             o_cell,
    output logic              o_le
);

    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_shift) begin
            n_cell = i_next;
        end else if (i_wr) begin
            n_cell.avail = i_wr_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.avail <= '0;
            r_cell.id    <= POS;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
    assign o_le   = ({1'b0, r_cell.id} < i_active) && (r_cell.avail <= i_cmp_time);

endmodule

// ===== rtl/earliest_k_resource_selector_unit.sv =====
// top level: ring of availability cells with a sequencer for write, select and check words
// Write, check and error words give one result each. A select word makes the availability
// ring (N = min(MAX_WORKERS, 16) cells) rotate once to find the k-th smallest time, then
// once more to emit matching indices in index order, pausing while the output stalls. When
// the ready date already frees k resources the first rotation is skipped. The ring rotates
// one cell per cycle unless an output stall holds it, and is always back at rest when idle.
module earliest_k_resource_selector_unit import ekrs_pkg::*; #(
    parameter int MAX_WORKERS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out             o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int NCELL = (MAX_WORKERS < RES_CAP) ? MAX_WORKERS : RES_CAP;
    localparam int CW = $clog2(NCELL);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_active;
    logic [CNT_W-1:0]  r_k;
    logic [TIME_W-1:0] r_t, n_t;
    logic              r_found, n_found;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_emitted, n_emitted;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    t_cell             cells [NCELL];
    logic [NCELL-1:0]  le;
    logic [CNT_W-1:0]  n_act;
    logic [TIME_W-1:0] cmp_time;
    logic [CNT_W-1:0]  pop;
    logic              shift;
    logic              wr;
    logic              out_free;
    logic              accept;
    logic              bad_k;
    logic              ring_end;
    logic              want;

    assign n_act = (r_active > CNT_W'(NCELL)) ? CNT_W'(NCELL) : r_active;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready = (r_state == ST_IDLE) && out_free;
    assign accept = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_out_valid;
    assign o_data = r_out;
    assign ring_end = (r_cnt == CW'(NCELL - 1));
    assign bad_k = (i_data.worker_count == '0) || (i_data.worker_count > n_act);
    assign want = le[0] && (r_emitted < r_k);

    always_comb begin
        cmp_time = r_t;
        case (r_state)
            ST_IDLE: cmp_time = (i_data.req_type == REQ_CHECK) ? i_data.begin_time
                                                               : i_data.time_value;
            ST_RANK: cmp_time = cells[0].avail;
            ST_EMIT: cmp_time = r_t;
            default: cmp_time = r_t;
        endcase
    end

    always_comb begin
        pop = '0;
        for (int i = 0; i < NCELL; i++) begin
            pop = pop + CNT_W'(le[i]);
        end
    end

    assign wr = accept && (i_data.req_type == REQ_WRITE);

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            ekrs_cell #(.POS(IDX_W'(g))) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (shift),
                .i_next     (cells[(g + 1) % NCELL]),
                .i_wr       (wr && (i_data.worker_id == IDX_W'(g))),
                .i_wr_time  (i_data.time_value),
                .i_cmp_time (cmp_time),
                .i_active   (n_act),
                .o_cell     (cells[g]),
                .o_le       (le[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_data.req_type == REQ_SELECT) && !bad_k) begin
                    n_state = (pop >= i_data.worker_count) ? ST_EMIT : ST_RANK;
                end
            end
            ST_RANK: begin
                if (ring_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (shift && ring_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        shift       = 1'b0;
        n_t         = r_t;
        n_found     = r_found;
        n_cnt       = r_cnt;
        n_emitted   = r_emitted;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            ST_IDLE: begin
                n_cnt     = '0;
                n_emitted = '0;
                n_found   = 1'b0;
                n_t       = i_data.time_value;
                if (accept && (i_data.req_type != REQ_RESERVED)) begin
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_data.req_type == REQ_WRITE) begin
                        n_out.ok = (32'(i_data.worker_id) < MAX_WORKERS);
                    end else if (bad_k) begin
                        n_out.error = 1'b1;
                    end else if (i_data.req_type == REQ_CHECK) begin
                        n_out.ok = (i_data.time_value <= i_data.begin_time) &&
                                   (pop >= i_data.worker_count);
                    end else begin
                        n_out_valid = 1'b0;
                    end
                end
            end
            ST_RANK: begin
                shift = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (({1'b0, cells[0].id} < n_act) && (pop >= r_k) &&
                    (!r_found || (cells[0].avail < r_t))) begin
                    n_t     = cells[0].avail;
                    n_found = 1'b1;
                end
                if (ring_end) begin
                    n_cnt = '0;
                end
            end
            ST_EMIT: begin
                if (!want || out_free) begin
                    shift = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (want) begin
                        n_out.worker_index = cells[0].id;
                        n_out.start_time   = r_t;
                        n_out.ok           = 1'b1;
                        n_out.error        = 1'b0;
                        n_out.last         = (r_emitted + 1'b1 == r_k);
                        n_out_valid        = 1'b1;
                        n_emitted          = r_emitted + 1'b1;
                    end
                    if (ring_end) begin
                        n_cnt = '0;
                    end
                end
            end
            default: begin
                shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= CNT_W'(RES_CAP);
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_emitted   <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_emitted   <= n_emitted;
            r_found     <= n_found;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_out <= n_out;
        if (accept) begin
            r_k <= i_data.worker_count;
        end
    end

endmodule
